[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the particle step block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, off during reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Implication into the next cycle, checked during reset too.
`define ASSERT_NXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

[hw/rtl/cfps_pkg.sv]
// ---------------------------------------------------------------------------
// cfps_pkg
// Types, constants and helper functions of the central force particle step.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfps_pkg;

    localparam int CFPS_SQRT_STEPS = 32;
    localparam int CFPS_DIV_STEPS  = 24;
    localparam int CFPS_NUM_W      = 58;
    localparam int CFPS_DEN_W      = 64;
    localparam int CFPS_SH_W       = CFPS_DEN_W + CFPS_DIV_STEPS;
    localparam int CFPS_CORDIC_STEPS = 20;

    typedef logic [CFPS_NUM_W-1:0]     t_num;
    typedef logic [CFPS_DEN_W-1:0]     t_den;
    typedef logic [CFPS_SH_W-1:0]      t_shv;
    typedef logic [CFPS_DIV_STEPS-1:0] t_quo;
    typedef logic signed [35:0]        t_cw;
    typedef logic signed [34:0]        t_s35;
    typedef logic signed [49:0]        t_s50;

    localparam logic [30:0] CFPS_MAX_FORCE_RST = 31'd65536;
    // 1000 in Q10.48 over a Q32.32 distance squared gives a Q8.16 quotient
    localparam t_num CFPS_FORCE_NUM = t_num'(1000) << 48;
    // softening floor 5.0 in Q32.32
    localparam t_den CFPS_SOFT_MIN = t_den'(5) << 32;
    // 0.9 in Q0.16
    localparam logic signed [17:0] CFPS_NINE = 18'sd58982;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic [63:0]        d2;
        logic [31:0]        root;
        t_quo               force_mag;
        logic               d2_zero;
    } t_side;

    typedef struct packed {
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nvx;
        logic signed [31:0] nvy;
    } t_res;

    function automatic logic [31:0] atan_angle(input logic [4:0] idx);
        logic [31:0] a;
        begin
            case (idx)
                5'd0:    a = 32'd536870912;
                5'd1:    a = 32'd316933406;
                5'd2:    a = 32'd167458907;
                5'd3:    a = 32'd85004756;
                5'd4:    a = 32'd42667331;
                5'd5:    a = 32'd21354465;
                5'd6:    a = 32'd10679838;
                5'd7:    a = 32'd5340245;
                5'd8:    a = 32'd2670163;
                5'd9:    a = 32'd1335087;
                5'd10:   a = 32'd667544;
                5'd11:   a = 32'd333772;
                5'd12:   a = 32'd166886;
                5'd13:   a = 32'd83443;
                5'd14:   a = 32'd41722;
                5'd15:   a = 32'd20861;
                5'd16:   a = 32'd10430;
                5'd17:   a = 32'd5215;
                5'd18:   a = 32'd2608;
                5'd19:   a = 32'd1304;
                default: a = 32'd0;
            endcase
            return a;
        end
    endfunction

    // divide by 65536, truncating toward zero
    function automatic logic signed [33:0] scale_down(input t_s50 p);
        t_s50 a;
        begin
            a = p[49] ? p + 50'sd65535 : p;
            return 34'(a >>> 16);
        end
    endfunction

    function automatic logic signed [31:0] sat32(input t_s35 v);
        begin
            if (v > 35'sd2147483647) begin
                return 32'sh7FFFFFFF;
            end else if (v < -35'sd2147483648) begin
                return 32'sh80000000;
            end else begin
                return v[31:0];
            end
        end
    endfunction

endpackage

[hw/rtl/cfps_if.sv]
// ---------------------------------------------------------------------------
// cfps_if
// Valid/ready channels for particle items in and step results out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cfps_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_pos;
    logic signed [31:0] y_pos;
    logic signed [31:0] x_vel;
    logic signed [31:0] y_vel;

    modport source(output valid, output x_pos, output y_pos, output x_vel,
                   output y_vel, input ready);
    modport sink(input valid, input x_pos, input y_pos, input x_vel,
                 input y_vel, output ready);
endinterface

interface cfps_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_x_pos;
    logic signed [31:0] new_y_pos;
    logic signed [31:0] new_x_vel;
    logic signed [31:0] new_y_vel;
    logic signed [15:0] heading;

    modport source(output valid, output new_x_pos, output new_y_pos,
                   output new_x_vel, output new_y_vel, output heading, input ready);
    modport sink(input valid, input new_x_pos, input new_y_pos,
                 input new_x_vel, input new_y_vel, input heading, output ready);
endinterface

[hw/rtl/cfps_sqrt.sv]
// ---------------------------------------------------------------------------
// cfps_sqrt
// Pipelined integer square root of a 64-bit value, one root bit per stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfps_sqrt (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [63:0]     i_rad,
    input  cfps_pkg::t_side i_side,
    output logic            o_valid,
    output logic [31:0]     o_root,
    output cfps_pkg::t_side o_side
);

    logic            r_v   [cfps_pkg::CFPS_SQRT_STEPS];
    logic [63:0]     r_n   [cfps_pkg::CFPS_SQRT_STEPS];
    logic [63:0]     r_res [cfps_pkg::CFPS_SQRT_STEPS];
    cfps_pkg::t_side r_sd  [cfps_pkg::CFPS_SQRT_STEPS];

    for (genvar g = 0; g < cfps_pkg::CFPS_SQRT_STEPS; g++) begin : g_stage
        logic            src_v;
        logic [63:0]     src_n;
        logic [63:0]     src_res;
        cfps_pkg::t_side src_sd;
        logic [63:0]     bitv;
        logic [63:0]     trial;

        if (g == 0) begin : g_first
            assign src_v   = i_valid;
            assign src_n   = i_rad;
            assign src_res = 64'd0;
            assign src_sd  = i_side;
        end else begin : g_next
            assign src_v   = r_v[g-1];
            assign src_n   = r_n[g-1];
            assign src_res = r_res[g-1];
            assign src_sd  = r_sd[g-1];
        end

        assign bitv  = 64'd1 << (62 - 2 * g);
        assign trial = src_res + bitv;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= src_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (src_n >= trial) begin
                    r_n[g]   <= src_n - trial;
                    r_res[g] <= (src_res >> 1) + bitv;
                end else begin
                    r_n[g]   <= src_n;
                    r_res[g] <= src_res >> 1;
                end
                r_sd[g] <= src_sd;
            end
        end
    end

    assign o_valid = r_v[cfps_pkg::CFPS_SQRT_STEPS-1];
    assign o_root  = r_res[cfps_pkg::CFPS_SQRT_STEPS-1][31:0];
    assign o_side  = r_sd[cfps_pkg::CFPS_SQRT_STEPS-1];

endmodule

[hw/rtl/cfps_div.sv]
// ---------------------------------------------------------------------------
// cfps_div
// Pipelined restoring divider, one quotient bit per stage, 24-bit quotient.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfps_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  cfps_pkg::t_num  i_num,
    input  cfps_pkg::t_den  i_den,
    input  cfps_pkg::t_side i_side,
    output logic            o_valid,
    output cfps_pkg::t_quo  o_quo,
    output cfps_pkg::t_side o_side
);

    localparam int STEPS = cfps_pkg::CFPS_DIV_STEPS;

    logic            r_v   [STEPS];
    cfps_pkg::t_num  r_rem [STEPS];
    cfps_pkg::t_den  r_d   [STEPS];
    cfps_pkg::t_quo  r_q   [STEPS];
    cfps_pkg::t_side r_sd  [STEPS];

    for (genvar g = 0; g < STEPS; g++) begin : g_stage
        logic            src_v;
        cfps_pkg::t_num  src_rem;
        cfps_pkg::t_den  src_d;
        cfps_pkg::t_quo  src_q;
        cfps_pkg::t_side src_sd;
        cfps_pkg::t_shv  dsh;
        logic            ge;

        if (g == 0) begin : g_first
            assign src_v   = i_valid;
            assign src_rem = i_num;
            assign src_d   = i_den;
            assign src_q   = '0;
            assign src_sd  = i_side;
        end else begin : g_next
            assign src_v   = r_v[g-1];
            assign src_rem = r_rem[g-1];
            assign src_d   = r_d[g-1];
            assign src_q   = r_q[g-1];
            assign src_sd  = r_sd[g-1];
        end

        // divisor aligned to the quotient bit of this stage
        assign dsh = cfps_pkg::t_shv'(src_d) << (STEPS - 1 - g);
        assign ge  = cfps_pkg::t_shv'(src_rem) >= dsh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= src_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= ge ? src_rem - dsh[cfps_pkg::CFPS_NUM_W-1:0] : src_rem;
                r_q[g]   <= {src_q[STEPS-2:0], ge};
                r_d[g]   <= src_d;
                r_sd[g]  <= src_sd;
            end
        end
    end

    assign o_valid = r_v[STEPS-1];
    assign o_quo   = r_q[STEPS-1];
    assign o_side  = r_sd[STEPS-1];

endmodule

[hw/rtl/cfps_cordic.sv]
// ---------------------------------------------------------------------------
// cfps_cordic
// Pipelined CORDIC vectoring: binary-angle heading of the new velocity.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfps_cordic (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  cfps_pkg::t_res     i_res,
    output logic               o_valid,
    output cfps_pkg::t_res     o_res,
    output logic signed [15:0] o_heading
);

    localparam int STEPS = cfps_pkg::CFPS_CORDIC_STEPS;

    // pre-rotation stage
    logic           r_p_v;
    logic           r_p_zero;
    cfps_pkg::t_cw  r_p_cx;
    cfps_pkg::t_cw  r_p_cy;
    logic [31:0]    r_p_z;
    cfps_pkg::t_res r_p_res;

    logic           r_v    [STEPS];
    logic           r_zero [STEPS];
    cfps_pkg::t_cw  r_cx   [STEPS];
    cfps_pkg::t_cw  r_cy   [STEPS];
    logic [31:0]    r_z    [STEPS];
    cfps_pkg::t_res r_res  [STEPS];

    cfps_pkg::t_cw vx_ext;
    cfps_pkg::t_cw vy_ext;
    logic [31:0]   z_round;

    assign vx_ext = cfps_pkg::t_cw'(i_res.nvx);
    assign vy_ext = cfps_pkg::t_cw'(i_res.nvy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (i_en) begin
            r_p_v <= i_valid;
        end
    end

    // turn a left-pointing vector by pi so the iterations converge
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_zero <= (i_res.nvx == 32'sd0) && (i_res.nvy == 32'sd0);
            r_p_res  <= i_res;
            if (i_res.nvx[31]) begin
                r_p_cx <= -vx_ext;
                r_p_cy <= -vy_ext;
                r_p_z  <= 32'h8000_0000;
            end else begin
                r_p_cx <= vx_ext;
                r_p_cy <= vy_ext;
                r_p_z  <= 32'd0;
            end
        end
    end

    for (genvar g = 0; g < STEPS; g++) begin : g_stage
        logic           src_v;
        logic           src_zero;
        cfps_pkg::t_cw  src_cx;
        cfps_pkg::t_cw  src_cy;
        logic [31:0]    src_z;
        cfps_pkg::t_res src_res;
        logic [31:0]    ang;

        if (g == 0) begin : g_first
            assign src_v    = r_p_v;
            assign src_zero = r_p_zero;
            assign src_cx   = r_p_cx;
            assign src_cy   = r_p_cy;
            assign src_z    = r_p_z;
            assign src_res  = r_p_res;
        end else begin : g_next
            assign src_v    = r_v[g-1];
            assign src_zero = r_zero[g-1];
            assign src_cx   = r_cx[g-1];
            assign src_cy   = r_cy[g-1];
            assign src_z    = r_z[g-1];
            assign src_res  = r_res[g-1];
        end

        assign ang = cfps_pkg::atan_angle(5'(g));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= src_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (src_cy > 36'sd0) begin
                    r_cx[g] <= src_cx + (src_cy >>> g);
                    r_cy[g] <= src_cy - (src_cx >>> g);
                    r_z[g]  <= src_z + ang;
                end else begin
                    r_cx[g] <= src_cx - (src_cy >>> g);
                    r_cy[g] <= src_cy + (src_cx >>> g);
                    r_z[g]  <= src_z - ang;
                end
                r_zero[g] <= src_zero;
                r_res[g]  <= src_res;
            end
        end
    end

    // round the 32-bit angle to 16 bits
    assign z_round   = r_z[STEPS-1] + 32'h0000_8000;
    assign o_valid   = r_v[STEPS-1];
    assign o_res     = r_res[STEPS-1];
    assign o_heading = r_zero[STEPS-1] ? 16'sd0 : $signed(z_round[31:16]);

endmodule

[hw/rtl/central_force_particle_step.sv]
// Central force particle step: one integration step of a particle toward the origin.
// Input channel i_in carries x_pos, y_pos, x_vel, y_vel (signed Q15.16); an item is
// taken at a rising edge with valid and ready both high. Output channel o_out carries
// the new position, new velocity and the heading of the new velocity (binary angle,
// -32768 is pi). Every item gives exactly one result, in order.
// Throughput: one item per cycle while the receiver does not stall. 111 registers lie
// on the path (2 square stages, the 32-stage square root, the 24-stage force divider,
// clamp and product stages, the 24-stage component dividers, 5 update stages, the
// 21-stage CORDIC, the output register) and the accepting edge loads the first of
// them.
// i_cfg_wr_en / i_cfg_wr_data write max_force (unsigned Q15.16), which clamps the force
// magnitude; write it only while no item is in flight.
// Reset (i_rst_n low at a clock edge) empties the pipeline and sets max_force to 1.0.
// When the receiver stalls, the result holds in the output register and the pipeline
// holds as a whole; while the stage feeding the output register is empty, the pipeline
// keeps moving and items are still accepted, so bubbles close up.
// ---------------------------------------------------------------------------
// central_force_particle_step
// Top level: squares, root, force divide, components, update and heading.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module central_force_particle_step (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [30:0] i_cfg_wr_data,
    cfps_in_if.sink     i_in,
    cfps_out_if.source  o_out
);

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [30:0] r_max_force;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_force <= cfps_pkg::CFPS_MAX_FORCE_RST;
        end else if (i_cfg_wr_en) begin
            r_max_force <= i_cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Flow control: one enable for the whole pipeline. Advance whenever
    // the output register is free, or the last stage carries nothing.
    // ------------------------------------------------------------------
    logic           en;
    logic           out_free;
    logic           cd_v;
    cfps_pkg::t_res cd_res;
    logic signed [15:0] cd_heading;

    logic               r_o_v;
    cfps_pkg::t_res     r_o_res;
    logic signed [15:0] r_o_heading;

    assign out_free   = !r_o_v || o_out.ready;
    assign en         = out_free || !cd_v;
    assign i_in.ready = en;

    // ------------------------------------------------------------------
    // Stage 1: magnitudes and squares
    // ------------------------------------------------------------------
    logic [31:0]     ux_in;
    logic [31:0]     uy_in;
    logic            r_s1_v;
    logic [63:0]     r_s1_xx;
    logic [63:0]     r_s1_yy;
    cfps_pkg::t_side r_s1_side;
    cfps_pkg::t_side n_s1_side;

    assign ux_in = i_in.x_pos[31] ? (~i_in.x_pos + 32'd1) : i_in.x_pos;
    assign uy_in = i_in.y_pos[31] ? (~i_in.y_pos + 32'd1) : i_in.y_pos;

    always_comb begin
        n_s1_side    = '0;
        n_s1_side.x  = i_in.x_pos;
        n_s1_side.y  = i_in.y_pos;
        n_s1_side.vx = i_in.x_vel;
        n_s1_side.vy = i_in.y_vel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_xx   <= {32'd0, ux_in} * {32'd0, ux_in};
            r_s1_yy   <= {32'd0, uy_in} * {32'd0, uy_in};
            r_s1_side <= n_s1_side;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: distance squared (Q32.32, exact)
    // ------------------------------------------------------------------
    logic            r_s2_v;
    cfps_pkg::t_side r_s2_side;
    cfps_pkg::t_side n_s2_side;
    logic [63:0]     d2_sum;

    assign d2_sum = r_s1_xx + r_s1_yy;

    always_comb begin
        n_s2_side         = r_s1_side;
        n_s2_side.d2      = d2_sum;
        n_s2_side.d2_zero = (d2_sum == 64'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (en) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_side <= n_s2_side;
        end
    end

    // ------------------------------------------------------------------
    // Root of the distance squared
    // ------------------------------------------------------------------
    logic            sq_v;
    logic [31:0]     sq_root;
    cfps_pkg::t_side sq_side;
    cfps_pkg::t_side fd_in_side;
    cfps_pkg::t_den  soft_d2;

    cfps_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s2_v),
        .i_rad   (r_s2_side.d2),
        .i_side  (r_s2_side),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // soften the distance squared to at least 5.0
    assign soft_d2 = (sq_side.d2 < cfps_pkg::CFPS_SOFT_MIN) ? cfps_pkg::CFPS_SOFT_MIN
                                                            : sq_side.d2;

    always_comb begin
        fd_in_side      = sq_side;
        fd_in_side.root = sq_root;
    end

    // ------------------------------------------------------------------
    // Force magnitude: 1000 / softened distance squared
    // ------------------------------------------------------------------
    logic            fd_v;
    cfps_pkg::t_quo  fd_quo;
    cfps_pkg::t_side fd_side;

    cfps_div u_force_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_v),
        .i_num   (cfps_pkg::CFPS_FORCE_NUM),
        .i_den   (soft_d2),
        .i_side  (fd_in_side),
        .o_valid (fd_v),
        .o_quo   (fd_quo),
        .o_side  (fd_side)
    );

    // ------------------------------------------------------------------
    // Stage 3: clamp to max_force
    // ------------------------------------------------------------------
    logic            r_s3_v;
    cfps_pkg::t_side r_s3_side;
    cfps_pkg::t_side n_s3_side;

    always_comb begin
        n_s3_side = fd_side;
        if ({7'd0, fd_quo} > r_max_force) begin
            n_s3_side.force_mag = r_max_force[cfps_pkg::CFPS_DIV_STEPS-1:0];
        end else begin
            n_s3_side.force_mag = fd_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (en) begin
            r_s3_v <= fd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_side <= n_s3_side;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: force times each coordinate magnitude
    // ------------------------------------------------------------------
    logic [31:0]     ux_s3;
    logic [31:0]     uy_s3;
    logic            r_s4_v;
    cfps_pkg::t_num  r_s4_px;
    cfps_pkg::t_num  r_s4_py;
    cfps_pkg::t_side r_s4_side;

    assign ux_s3 = r_s3_side.x[31] ? (~r_s3_side.x + 32'd1) : r_s3_side.x;
    assign uy_s3 = r_s3_side.y[31] ? (~r_s3_side.y + 32'd1) : r_s3_side.y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else if (en) begin
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_px   <= cfps_pkg::t_num'(r_s3_side.force_mag) * cfps_pkg::t_num'(ux_s3);
            r_s4_py   <= cfps_pkg::t_num'(r_s3_side.force_mag) * cfps_pkg::t_num'(uy_s3);
            r_s4_side <= r_s3_side;
        end
    end

    // ------------------------------------------------------------------
    // Components: force * |coordinate| / root, one divider per axis
    // ------------------------------------------------------------------
    logic            dx_v;
    cfps_pkg::t_quo  dx_quo;
    cfps_pkg::t_side dx_side;
    logic            dy_v;
    cfps_pkg::t_quo  dy_quo;
    cfps_pkg::t_side dy_side;

    cfps_div u_x_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s4_v),
        .i_num   (r_s4_px),
        .i_den   (cfps_pkg::t_den'(r_s4_side.root)),
        .i_side  (r_s4_side),
        .o_valid (dx_v),
        .o_quo   (dx_quo),
        .o_side  (dx_side)
    );

    cfps_div u_y_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s4_v),
        .i_num   (r_s4_py),
        .i_den   (cfps_pkg::t_den'(r_s4_side.root)),
        .i_side  (r_s4_side),
        .o_valid (dy_v),
        .o_quo   (dy_quo),
        .o_side  (dy_side)
    );

    // ------------------------------------------------------------------
    // Stage 5: signed acceleration, pointing toward the origin
    // ------------------------------------------------------------------
    logic signed [24:0] f_ext;
    logic signed [24:0] qx_ext;
    logic signed [24:0] qy_ext;
    logic               r_s5_v;
    logic signed [24:0] r_s5_ax;
    logic signed [24:0] r_s5_ay;
    logic signed [31:0] r_s5_x;
    logic signed [31:0] r_s5_y;
    logic signed [31:0] r_s5_vx;
    logic signed [31:0] r_s5_vy;

    assign f_ext  = $signed({1'b0, dx_side.force_mag});
    assign qx_ext = $signed({1'b0, dx_quo});
    assign qy_ext = $signed({1'b0, dy_quo});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_v <= 1'b0;
        end else if (en) begin
            r_s5_v <= dx_v && dy_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // at the origin push along -x with the full magnitude
            if (dx_side.d2_zero) begin
                r_s5_ax <= -f_ext;
                r_s5_ay <= 25'sd0;
            end else begin
                r_s5_ax <= dx_side.x[31] ? qx_ext : -qx_ext;
                r_s5_ay <= dy_side.y[31] ? qy_ext : -qy_ext;
            end
            r_s5_x  <= dx_side.x;
            r_s5_y  <= dy_side.y;
            r_s5_vx <= dx_side.vx;
            r_s5_vy <= dx_side.vy;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: acceleration times 0.9
    // ------------------------------------------------------------------
    logic               r_s6_v;
    logic signed [42:0] r_s6_mx;
    logic signed [42:0] r_s6_my;
    logic signed [31:0] r_s6_x;
    logic signed [31:0] r_s6_y;
    logic signed [31:0] r_s6_vx;
    logic signed [31:0] r_s6_vy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_v <= 1'b0;
        end else if (en) begin
            r_s6_v <= r_s5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s6_mx <= r_s5_ax * cfps_pkg::CFPS_NINE;
            r_s6_my <= r_s5_ay * cfps_pkg::CFPS_NINE;
            r_s6_x  <= r_s5_x;
            r_s6_y  <= r_s5_y;
            r_s6_vx <= r_s5_vx;
            r_s6_vy <= r_s5_vy;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: new velocity, saturated
    // ------------------------------------------------------------------
    logic               r_s7_v;
    logic signed [31:0] r_s7_nvx;
    logic signed [31:0] r_s7_nvy;
    logic signed [31:0] r_s7_x;
    logic signed [31:0] r_s7_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_v <= 1'b0;
        end else if (en) begin
            r_s7_v <= r_s6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s7_nvx <= cfps_pkg::sat32(cfps_pkg::t_s35'(r_s6_vx) + cfps_pkg::t_s35'(
                        cfps_pkg::scale_down(cfps_pkg::t_s50'(r_s6_mx))));
            r_s7_nvy <= cfps_pkg::sat32(cfps_pkg::t_s35'(r_s6_vy) + cfps_pkg::t_s35'(
                        cfps_pkg::scale_down(cfps_pkg::t_s50'(r_s6_my))));
            r_s7_x   <= r_s6_x;
            r_s7_y   <= r_s6_y;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: new velocity times 0.9
    // ------------------------------------------------------------------
    logic               r_s8_v;
    cfps_pkg::t_s50     r_s8_mx;
    cfps_pkg::t_s50     r_s8_my;
    logic signed [31:0] r_s8_nvx;
    logic signed [31:0] r_s8_nvy;
    logic signed [31:0] r_s8_x;
    logic signed [31:0] r_s8_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8_v <= 1'b0;
        end else if (en) begin
            r_s8_v <= r_s7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s8_mx  <= r_s7_nvx * cfps_pkg::CFPS_NINE;
            r_s8_my  <= r_s7_nvy * cfps_pkg::CFPS_NINE;
            r_s8_nvx <= r_s7_nvx;
            r_s8_nvy <= r_s7_nvy;
            r_s8_x   <= r_s7_x;
            r_s8_y   <= r_s7_y;
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: new position, saturated
    // ------------------------------------------------------------------
    logic           r_s9_v;
    cfps_pkg::t_res r_s9_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s9_v <= 1'b0;
        end else if (en) begin
            r_s9_v <= r_s8_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s9_res.nx  <= cfps_pkg::sat32(cfps_pkg::t_s35'(r_s8_x) +
                            cfps_pkg::t_s35'(cfps_pkg::scale_down(r_s8_mx)));
            r_s9_res.ny  <= cfps_pkg::sat32(cfps_pkg::t_s35'(r_s8_y) +
                            cfps_pkg::t_s35'(cfps_pkg::scale_down(r_s8_my)));
            r_s9_res.nvx <= r_s8_nvx;
            r_s9_res.nvy <= r_s8_nvy;
        end
    end

    // ------------------------------------------------------------------
    // Heading of the new velocity
    // ------------------------------------------------------------------
    cfps_cordic u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (r_s9_v),
        .i_res     (r_s9_res),
        .o_valid   (cd_v),
        .o_res     (cd_res),
        .o_heading (cd_heading)
    );

    // ------------------------------------------------------------------
    // Output register: load when free, hold while the receiver stalls
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (out_free) begin
            r_o_v <= cd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_o_res     <= cd_res;
            r_o_heading <= cd_heading;
        end
    end

    assign o_out.valid     = r_o_v;
    assign o_out.new_x_pos = r_o_res.nx;
    assign o_out.new_y_pos = r_o_res.ny;
    assign o_out.new_x_vel = r_o_res.nvx;
    assign o_out.new_y_vel = r_o_res.nvy;
    assign o_out.heading   = r_o_heading;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic out_vel_zero;

    assign out_vel_zero = (r_o_res.nvx == 32'sd0) && (r_o_res.nvy == 32'sd0);

    `ASSERT_NXT(a_cfg_reset, i_clk, !i_rst_n, r_max_force == cfps_pkg::CFPS_MAX_FORCE_RST)
    `ASSERT_IMP(a_force_clamp, i_clk, i_rst_n, r_s3_v, {7'd0, r_s3_side.force_mag} <= r_max_force)
    `ASSERT_IMP(a_zero_heading, i_clk, i_rst_n, o_out.valid && out_vel_zero, o_out.heading == 16'sd0)

endmodule
